// ----- src/u8v_pkg.sv -----
// Shared types and constants of the UTF-8 stream validator.
package u8v_pkg;

  // Default limit on string length; offsets saturate at the smaller of this and 16 bits.
  localparam int unsigned MAX_STRING_BYTES_DEF = 65535;
  localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

  localparam int unsigned CODE_W = 21;

  // Lowest code point allowed for 3 and 4 byte sequences.
  localparam logic [CODE_W-1:0] MIN_THREE = 21'h000800;
  localparam logic [CODE_W-1:0] MIN_FOUR  = 21'h010000;
  localparam logic [CODE_W-1:0] CODE_LIMIT = 21'h110000;
  // Surrogates share the upper bits 0xD800 >> 11.
  localparam logic [9:0]        SURR_HI   = 10'h01B;
  localparam logic [CODE_W-1:0] NONCHAR_LO = 21'h00FDD0;
  localparam logic [CODE_W-1:0] NONCHAR_HI = 21'h00FDEF;

  // Range check applied when a sequence completes.
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_THREE = 2'd1,
    CLS_FOUR  = 2'd2
  } cls_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic        is_valid;
    logic [15:0] end_offset;
  } out_t;

  typedef struct packed {
    logic [1:0]        pending;
    logic [CODE_W-1:0] code_value;
    cls_e              min_class;
    logic [15:0]       byte_offset;
    logic [15:0]       lead_offset;
    logic              skipping;
  } state_t;

  localparam state_t STATE_RESET = '{
    pending:     2'd0,
    code_value:  '0,
    min_class:   CLS_NONE,
    byte_offset: 16'd0,
    lead_offset: 16'd0,
    skipping:    1'b0
  };

endpackage

// ----- src/u8v_step.sv -----
// Next-state and result logic for one byte of the UTF-8 stream validator.
module u8v_step #(
  parameter logic [15:0] OffsetCeil = u8v_pkg::OFFSET_MAX
) (
  input  u8v_pkg::state_t state_i,
  input  u8v_pkg::in_t    item_i,
  output u8v_pkg::state_t state_o,
  output logic            res_valid_o,
  output u8v_pkg::out_t   res_o
);

  logic [7:0]                   b;
  logic                         last;
  logic [15:0]                  pos;
  logic [15:0]                  pos_next;
  logic                         fail;
  logic [15:0]                  fail_at;
  u8v_pkg::state_t              st;
  logic [u8v_pkg::CODE_W-1:0]   floor_value;
  logic [u8v_pkg::CODE_W-1:0]   code_new;
  logic                         code_ok;

  assign b    = item_i.data_byte;
  assign last = item_i.final_byte;
  assign pos  = state_i.byte_offset;
  assign pos_next = (pos < OffsetCeil) ? pos + 16'd1 : OffsetCeil;

  // Code point after merging this byte as a continuation byte.
  assign code_new = {state_i.code_value[u8v_pkg::CODE_W-7:0], b[5:0]};

  always_comb begin
    floor_value = (state_i.min_class == u8v_pkg::CLS_FOUR) ? u8v_pkg::MIN_FOUR
                                                           : u8v_pkg::MIN_THREE;
    code_ok = 1'b1;
    if (code_new < floor_value) code_ok = 1'b0;
    if (code_new >= u8v_pkg::CODE_LIMIT) code_ok = 1'b0;
    if (code_new[20:11] == u8v_pkg::SURR_HI) code_ok = 1'b0;
    if (code_new >= u8v_pkg::NONCHAR_LO && code_new <= u8v_pkg::NONCHAR_HI) code_ok = 1'b0;
    if (&code_new[15:1]) code_ok = 1'b0;
  end

  always_comb begin
    st          = state_i;
    fail        = 1'b0;
    fail_at     = 16'd0;
    res_valid_o = 1'b0;
    res_o       = '{is_valid: 1'b0, end_offset: 16'd0};
    state_o     = state_i;

    if (state_i.skipping) begin
      // Drop bytes of a failed string until its end.
      if (b == 8'd0 || last) begin
        state_o = u8v_pkg::STATE_RESET;
      end
    end else if (state_i.pending == 2'd0 && b == 8'd0) begin
      res_valid_o = 1'b1;
      res_o       = '{is_valid: 1'b1, end_offset: pos};
      state_o     = u8v_pkg::STATE_RESET;
    end else begin
      if (state_i.pending == 2'd0) begin
        if (b[7]) begin
          st.lead_offset = pos;
          fail_at        = pos;
          if (b[7:5] == 3'b110) begin
            if (b[4:1] == 4'd0) fail = 1'b1;
            st.pending    = 2'd1;
            st.code_value = {16'd0, b[4:0]};
            st.min_class  = u8v_pkg::CLS_NONE;
          end else if (b[7:4] == 4'b1110) begin
            st.pending    = 2'd2;
            st.code_value = {17'd0, b[3:0]};
            st.min_class  = u8v_pkg::CLS_THREE;
          end else if (b[7:3] == 5'b11110) begin
            st.pending    = 2'd3;
            st.code_value = {18'd0, b[2:0]};
            st.min_class  = u8v_pkg::CLS_FOUR;
          end else begin
            fail = 1'b1;
          end
        end
      end else begin
        fail_at = state_i.lead_offset;
        if (b[7:6] != 2'b10) begin
          fail = 1'b1;
        end else begin
          st.code_value = code_new;
          st.pending    = state_i.pending - 2'd1;
          if (st.pending == 2'd0 && state_i.min_class != u8v_pkg::CLS_NONE && !code_ok) begin
            fail = 1'b1;
          end
        end
      end

      // The string ends in the middle of a sequence.
      if (!fail && last && st.pending != 2'd0) begin
        fail    = 1'b1;
        fail_at = st.lead_offset;
      end

      if (fail) begin
        res_valid_o      = 1'b1;
        res_o            = '{is_valid: 1'b0, end_offset: fail_at};
        state_o          = u8v_pkg::STATE_RESET;
        state_o.skipping = (b != 8'd0) && !last;
      end else if (last) begin
        res_valid_o = 1'b1;
        res_o       = '{is_valid: 1'b1, end_offset: pos_next};
        state_o     = u8v_pkg::STATE_RESET;
      end else begin
        state_o             = st;
        state_o.byte_offset = pos_next;
      end
    end
  end

endmodule

// ----- src/utf8_stream_validator.sv -----
// Top level of the UTF-8 stream validator: input register, byte step, result register.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (data_byte, final_byte)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (is_valid, end_offset)
//
// One byte is taken per cycle unless in_stall_o is raised; the byte that ends or breaks the
// string passes the input register and then the result register, which offers the result.
// Reset clears the string state and both valid flags.
// A stall on the output holds back the input only when the byte waiting in the input
// register would produce a result; bytes that produce none keep flowing.
module utf8_stream_validator #(
  parameter int unsigned MaxStringBytes = u8v_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  u8v_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output u8v_pkg::out_t out_data_o
);

  localparam logic [15:0] OffsetCeil =
    (MaxStringBytes < 32'(u8v_pkg::OFFSET_MAX)) ? MaxStringBytes[15:0] : u8v_pkg::OFFSET_MAX;

  logic            in_valid_q, in_valid_d;
  u8v_pkg::in_t    in_data_q;
  logic            out_valid_q, out_valid_d;
  u8v_pkg::out_t   out_data_q;
  u8v_pkg::state_t state_q, state_d;
  u8v_pkg::state_t step_state;
  logic            step_res_valid;
  u8v_pkg::out_t   step_res;
  logic            out_free;
  logic            proc_en;
  logic            in_xfer;

  u8v_step #(
    .OffsetCeil (OffsetCeil)
  ) u_step (
    .state_i     (state_q),
    .item_i      (in_data_q),
    .state_o     (step_state),
    .res_valid_o (step_res_valid),
    .res_o       (step_res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_en    = in_valid_q && (!step_res_valid || out_free);
  assign in_stall_o = in_valid_q && !proc_en;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_xfer ? 1'b1 : (proc_en ? 1'b0 : in_valid_q);
  assign out_valid_d = (proc_en && step_res_valid) ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  assign state_d     = proc_en ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= u8v_pkg::STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
    if (proc_en && step_res_valid) begin
      out_data_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A new result can only come from a byte held in the input register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result appeared without a byte to process");

  // While dropping a failed string no sequence is open.
  a_skip_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.skipping |-> (state_q.pending == 2'd0))
    else $error("open sequence while skipping");

  // An open sequence started at or before the current byte.
  a_lead_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pending != 2'd0) |-> (state_q.lead_offset <= state_q.byte_offset))
    else $error("lead offset past current offset");

endmodule
